// ===== src/partially_persistent_union_find_unit_defines.svh =====
// Assertion macros used by the union-find sequencer (ppuf_ctrl).
`ifndef PARTIALLY_PERSISTENT_UNION_FIND_UNIT_DEFINES_SVH
`define PARTIALLY_PERSISTENT_UNION_FIND_UNIT_DEFINES_SVH

// Same-cycle implication under reset.
`define PPUF_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define PPUF_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ppuf_pkg.sv =====
// Constants, codes and bundle types of the union-find unit.
`timescale 1ns / 1ps
package ppuf_pkg;

    localparam int VERTICES   = 1024;
    localparam int VTX_W      = $clog2(VERTICES);
    localparam int HIST_DEPTH = 16;
    localparam int HIDX_W     = $clog2(HIST_DEPTH);
    localparam int HCNT_W     = HIDX_W + 1;
    localparam int ENT_W      = VTX_W + HIDX_W;
    localparam int TIME_W     = 16;
    localparam int SIZE_W     = 11;
    localparam int NV_W       = 11;
    localparam int KIND_W     = 2;
    localparam int STAT_W     = 3;

    localparam logic [NV_W-1:0]   NV_RESET   = NV_W'(1024);
    localparam logic [TIME_W-1:0] TIME_NEVER = {TIME_W{1'b1}};
    localparam logic [TIME_W-1:0] TIME_LAST  = TIME_NEVER - TIME_W'(1);

    localparam logic [KIND_W-1:0] KIND_MERGE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SAME  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SIZE  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_VTX   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_LATE      = 3'd2;
    localparam logic [STAT_W-1:0] STAT_HIST_FULL = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 3'd4;

    typedef enum logic [7:0] {
        ST_CLEAR   = 8'b0000_0001,
        ST_IDLE    = 8'b0000_0010,
        ST_WALK_A  = 8'b0000_0100,
        ST_WALK_B  = 8'b0000_1000,
        ST_SZ_CNT  = 8'b0001_0000,
        ST_SZ_SCAN = 8'b0010_0000,
        ST_COMMIT  = 8'b0100_0000,
        ST_DONE    = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic              en;
        logic [VTX_W-1:0]  addr;
        logic [VTX_W-1:0]  parent;
        logic [TIME_W-1:0] stamp;
    } link_wr_t;

    typedef struct packed {
        logic [VTX_W-1:0]  parent;
        logic [TIME_W-1:0] stamp;
    } link_rd_t;

    typedef struct packed {
        logic              ent_en;
        logic [ENT_W-1:0]  ent_addr;
        logic [TIME_W-1:0] ent_time;
        logic [SIZE_W-1:0] ent_size;
        logic              cnt_en;
        logic [VTX_W-1:0]  cnt_addr;
        logic [HCNT_W-1:0] cnt_data;
    } hist_wr_t;

    typedef struct packed {
        logic [VTX_W-1:0] cnt_addr;
        logic [ENT_W-1:0] ent_addr;
    } hist_rq_t;

    typedef struct packed {
        logic [HCNT_W-1:0] cnt;
        logic [TIME_W-1:0] ent_time;
        logic [SIZE_W-1:0] ent_size;
    } hist_rd_t;

endpackage

// ===== src/ppuf_ifs.sv =====
// Handshake channels of the union-find unit: request, response, config.
`timescale 1ns / 1ps
interface ppuf_req_if import ppuf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [VTX_W-1:0]  vertex_a;
    logic [VTX_W-1:0]  vertex_b;
    logic [TIME_W-1:0] query_time;

    modport source (output valid, kind, vertex_a, vertex_b, query_time, input ready);
    modport sink (input valid, kind, vertex_a, vertex_b, query_time, output ready);
endinterface

interface ppuf_rsp_if import ppuf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              answer_flag;
    logic [SIZE_W-1:0] component_size;
    logic [TIME_W-1:0] current_time;
    logic [STAT_W-1:0] status;

    modport source (output valid, answer_flag, component_size, current_time, status,
                    input ready);
    modport sink (input valid, answer_flag, component_size, current_time, status,
                  output ready);
endinterface

interface ppuf_cfg_if import ppuf_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [NV_W-1:0] num_vertices;

    modport source (output valid, num_vertices, input ready);
    modport sink (input valid, num_vertices, output ready);
endinterface

// ===== src/partially_persistent_union_find_unit.sv =====
// Top level of the partially persistent union-find unit.
// After reset the unit clears the link stamps and history counts of all 1024
// nodes and takes no request meanwhile; configuration writes are taken at any
// time. It then handles one word at a time. A request is accepted, each root
// walk then follows one link per registered read (depth at most 10), the size
// history of each root is read as its entry count and then up to 15 entries,
// a merge ends in a commit step, and the result is handed to the output
// register once the previous word has left it. A rejected or unknown request
// goes straight from acceptance to the output register.
// This flow is set by the single read port of the link and history memories,
// each step of the walk and of the history scan being one registered read.
// The result register lets the next request in while a response still waits.
`timescale 1ns / 1ps
module partially_persistent_union_find_unit import ppuf_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    ppuf_cfg_if.sink   cfg,
    ppuf_req_if.sink   req,
    ppuf_rsp_if.source rsp
);

    logic [VTX_W-1:0] link_rd_addr;
    link_rd_t         link_rd;
    link_wr_t         link_wr;
    hist_rq_t         hist_rq;
    hist_rd_t         hist_rd;
    hist_wr_t         hist_wr;

    ppuf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .req          (req),
        .rsp          (rsp),
        .link_rd_addr (link_rd_addr),
        .link_rd      (link_rd),
        .link_wr      (link_wr),
        .hist_rq      (hist_rq),
        .hist_rd      (hist_rd),
        .hist_wr      (hist_wr)
    );

    ppuf_link_store u_link (
        .clk     (clk),
        .rd_addr (link_rd_addr),
        .rd      (link_rd),
        .wr      (link_wr)
    );

    ppuf_hist_store u_hist (
        .clk (clk),
        .rq  (hist_rq),
        .rd  (hist_rd),
        .wr  (hist_wr)
    );

endmodule

// ===== src/ppuf_link_store.sv =====
// Parent link memory: parent pointer and merge stamp per node.
`timescale 1ns / 1ps
module ppuf_link_store import ppuf_pkg::*; (
    input  logic             clk,
    input  logic [VTX_W-1:0] rd_addr,
    output link_rd_t         rd,
    input  link_wr_t         wr
);

    logic [VTX_W-1:0]  parent_mem [VERTICES];
    logic [TIME_W-1:0] stamp_mem  [VERTICES];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            parent_mem[wr.addr] <= wr.parent;
            stamp_mem[wr.addr]  <= wr.stamp;
        end
        rd.parent <= parent_mem[rd_addr];
        rd.stamp  <= stamp_mem[rd_addr];
    end

endmodule

// ===== src/ppuf_hist_store.sv =====
// Size history memories: per-root entry count and (time, size) entries.
`timescale 1ns / 1ps
module ppuf_hist_store import ppuf_pkg::*; (
    input  logic     clk,
    input  hist_rq_t rq,
    output hist_rd_t rd,
    input  hist_wr_t wr
);

    logic [HCNT_W-1:0] cnt_mem  [VERTICES];
    logic [TIME_W-1:0] time_mem [VERTICES * HIST_DEPTH];
    logic [SIZE_W-1:0] size_mem [VERTICES * HIST_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.cnt_en)
        begin
            cnt_mem[wr.cnt_addr] <= wr.cnt_data;
        end
        rd.cnt <= cnt_mem[rq.cnt_addr];
    end

    // entry 0 of every root is never stored; the scan starts at entry 1
    always_ff @(posedge clk)
    begin
        if (wr.ent_en)
        begin
            time_mem[wr.ent_addr] <= wr.ent_time;
            size_mem[wr.ent_addr] <= wr.ent_size;
        end
        rd.ent_time <= time_mem[rq.ent_addr];
        rd.ent_size <= size_mem[rq.ent_addr];
    end

endmodule

// ===== src/ppuf_ctrl.sv =====
// Sequencer: reset clear, root walks, size-history scan, merge commit and handshakes.
`timescale 1ns / 1ps
`include "partially_persistent_union_find_unit_defines.svh"
module ppuf_ctrl import ppuf_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    ppuf_cfg_if.sink         cfg,
    ppuf_req_if.sink         req,
    ppuf_rsp_if.source       rsp,
    output logic [VTX_W-1:0] link_rd_addr,
    input  link_rd_t         link_rd,
    output link_wr_t         link_wr,
    output hist_rq_t         hist_rq,
    input  hist_rd_t         hist_rd,
    output hist_wr_t         hist_wr
);

    state_t            state_reg, state_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [TIME_W-1:0] time_now_reg, time_now_next;
    logic [NV_W-1:0]   nv_reg, nv_next;
    logic [VTX_W-1:0]  clr_reg, clr_next;

    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [VTX_W-1:0]  vb_reg, vb_next;
    logic [TIME_W-1:0] t_reg, t_next;
    logic [VTX_W-1:0]  cur_reg, cur_next;
    logic [VTX_W-1:0]  ra_reg, ra_next;
    logic [VTX_W-1:0]  rb_reg, rb_next;
    logic [VTX_W-1:0]  scan_root_reg, scan_root_next;
    logic              scan_b_reg, scan_b_next;
    logic [HCNT_W-1:0] cnt_reg, cnt_next;
    logic [HCNT_W-1:0] cnt_a_reg, cnt_a_next;
    logic [HIDX_W-1:0] idx_reg, idx_next;
    logic [SIZE_W-1:0] acc_reg, acc_next;
    logic [SIZE_W-1:0] sa_reg, sa_next;
    logic [SIZE_W-1:0] sb_reg, sb_next;
    logic              res_flag_reg, res_flag_next;
    logic [SIZE_W-1:0] res_size_reg, res_size_next;
    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic              out_flag_reg, out_flag_next;
    logic [SIZE_W-1:0] out_size_reg, out_size_next;
    logic [TIME_W-1:0] out_time_reg, out_time_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;

    logic              a_ok, b_ok, q_late, follow;
    logic              scan_fin;
    logic [SIZE_W-1:0] fin_size;
    logic [HCNT_W-1:0] fin_cnt;
    logic [HCNT_W-1:0] idx_inc;
    logic              swap;
    logic [VTX_W-1:0]  win, lose;
    logic [HCNT_W-1:0] win_cnt;

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.answer_flag    = out_flag_reg;
    assign rsp.component_size = out_size_reg;
    assign rsp.current_time   = out_time_reg;
    assign rsp.status         = out_status_reg;

    assign a_ok    = {1'b0, req.vertex_a} < nv_reg;
    assign b_ok    = {1'b0, req.vertex_b} < nv_reg;
    assign q_late  = req.query_time > time_now_reg;
    // shared compare: link stamps during walks
    assign follow  = link_rd.stamp <= t_reg;
    assign idx_inc = {1'b0, idx_reg} + HCNT_W'(1);
    assign swap    = sa_reg < sb_reg;
    assign win     = swap ? rb_reg : ra_reg;
    assign lose    = swap ? ra_reg : rb_reg;
    assign win_cnt = swap ? cnt_reg : cnt_a_reg;

    always_comb
    begin
        state_next      = state_reg;
        rsp_valid_next  = rsp_valid_reg;
        time_now_next   = time_now_reg;
        nv_next         = nv_reg;
        clr_next        = clr_reg;
        kind_next       = kind_reg;
        vb_next         = vb_reg;
        t_next          = t_reg;
        cur_next        = cur_reg;
        ra_next         = ra_reg;
        rb_next         = rb_reg;
        scan_root_next  = scan_root_reg;
        scan_b_next     = scan_b_reg;
        cnt_next        = cnt_reg;
        cnt_a_next      = cnt_a_reg;
        idx_next        = idx_reg;
        acc_next        = acc_reg;
        sa_next         = sa_reg;
        sb_next         = sb_reg;
        res_flag_next   = res_flag_reg;
        res_size_next   = res_size_reg;
        res_status_next = res_status_reg;
        out_flag_next   = out_flag_reg;
        out_size_next   = out_size_reg;
        out_time_next   = out_time_reg;
        out_status_next = out_status_reg;

        link_rd_addr     = cur_reg;
        hist_rq.cnt_addr = cur_reg;
        hist_rq.ent_addr = {scan_root_reg, idx_reg};
        link_wr          = '0;
        hist_wr          = '0;
        scan_fin         = 1'b0;
        fin_size         = acc_reg;
        fin_cnt          = cnt_reg;

        if (cfg.valid)
        begin
            nv_next = cfg.num_vertices;
        end
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                link_wr.en       = 1'b1;
                link_wr.addr     = clr_reg;
                link_wr.stamp    = TIME_NEVER;
                hist_wr.cnt_en   = 1'b1;
                hist_wr.cnt_addr = clr_reg;
                hist_wr.cnt_data = HCNT_W'(1);
                clr_next         = clr_reg + VTX_W'(1);
                if (clr_reg == VTX_W'(VERTICES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next       = req.kind;
                    vb_next         = req.vertex_b;
                    cur_next        = req.vertex_a;
                    link_rd_addr    = req.vertex_a;
                    t_next          = req.query_time;
                    res_flag_next   = 1'b0;
                    res_size_next   = '0;
                    res_status_next = STAT_OK;
                    state_next      = ST_DONE;
                    case (req.kind)
                        KIND_MERGE:
                        begin
                            t_next = time_now_reg;
                            if (!(a_ok && b_ok))
                                res_status_next = STAT_BAD_VTX;
                            else if (time_now_reg >= TIME_LAST)
                                res_status_next = STAT_EXHAUSTED;
                            else
                                state_next = ST_WALK_A;
                        end
                        KIND_SAME:
                        begin
                            if (!(a_ok && b_ok))
                                res_status_next = STAT_BAD_VTX;
                            else if (q_late)
                                res_status_next = STAT_LATE;
                            else
                                state_next = ST_WALK_A;
                        end
                        KIND_SIZE:
                        begin
                            if (!a_ok)
                                res_status_next = STAT_BAD_VTX;
                            else if (q_late)
                                res_status_next = STAT_LATE;
                            else
                                state_next = ST_WALK_A;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_WALK_A:
            begin
                if (follow)
                begin
                    cur_next     = link_rd.parent;
                    link_rd_addr = link_rd.parent;
                end
                else
                begin
                    ra_next = cur_reg;
                    if (kind_reg == KIND_SIZE)
                    begin
                        scan_root_next = cur_reg;
                        scan_b_next    = 1'b0;
                        state_next     = ST_SZ_CNT;
                    end
                    else
                    begin
                        cur_next     = vb_reg;
                        link_rd_addr = vb_reg;
                        state_next   = ST_WALK_B;
                    end
                end
            end
            ST_WALK_B:
            begin
                if (follow)
                begin
                    cur_next     = link_rd.parent;
                    link_rd_addr = link_rd.parent;
                end
                else
                begin
                    rb_next = cur_reg;
                    if (kind_reg == KIND_SAME)
                    begin
                        res_flag_next = (ra_reg == cur_reg);
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        // a merge that gets this far always opens a new time step
                        time_now_next = time_now_reg + TIME_W'(1);
                        if (ra_reg == cur_reg)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            hist_rq.cnt_addr = ra_reg;
                            scan_root_next   = ra_reg;
                            scan_b_next      = 1'b0;
                            state_next       = ST_SZ_CNT;
                        end
                    end
                end
            end
            ST_SZ_CNT:
            begin
                cnt_next         = hist_rd.cnt;
                acc_next         = SIZE_W'(1);
                idx_next         = HIDX_W'(1);
                hist_rq.ent_addr = {scan_root_reg, HIDX_W'(1)};
                if (hist_rd.cnt > HCNT_W'(1))
                begin
                    state_next = ST_SZ_SCAN;
                end
                else
                begin
                    scan_fin = 1'b1;
                    fin_size = SIZE_W'(1);
                    fin_cnt  = hist_rd.cnt;
                end
            end
            ST_SZ_SCAN:
            begin
                if (hist_rd.ent_time <= t_reg)
                begin
                    acc_next = hist_rd.ent_size;
                    if (idx_inc < cnt_reg)
                    begin
                        idx_next         = idx_inc[HIDX_W-1:0];
                        hist_rq.ent_addr = {scan_root_reg, idx_inc[HIDX_W-1:0]};
                    end
                    else
                    begin
                        scan_fin = 1'b1;
                        fin_size = hist_rd.ent_size;
                    end
                end
                else
                begin
                    scan_fin = 1'b1;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_DONE;
                if (win_cnt >= HCNT_W'(HIST_DEPTH))
                begin
                    res_status_next = STAT_HIST_FULL;
                end
                else
                begin
                    link_wr.en       = 1'b1;
                    link_wr.addr     = lose;
                    link_wr.parent   = win;
                    link_wr.stamp    = time_now_reg;
                    hist_wr.ent_en   = 1'b1;
                    hist_wr.ent_addr = {win, win_cnt[HIDX_W-1:0]};
                    hist_wr.ent_time = time_now_reg;
                    hist_wr.ent_size = sa_reg + sb_reg;
                    hist_wr.cnt_en   = 1'b1;
                    hist_wr.cnt_addr = win;
                    hist_wr.cnt_data = win_cnt + HCNT_W'(1);
                    res_flag_next    = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    out_flag_next   = res_flag_reg;
                    out_size_next   = res_size_reg;
                    out_time_next   = time_now_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // end of a size scan: route the result to the owner
        if (scan_fin)
        begin
            if (kind_reg == KIND_SIZE)
            begin
                res_size_next = fin_size;
                state_next    = ST_DONE;
            end
            else if (!scan_b_reg)
            begin
                sa_next          = fin_size;
                cnt_a_next       = fin_cnt;
                scan_b_next      = 1'b1;
                scan_root_next   = rb_reg;
                hist_rq.cnt_addr = rb_reg;
                state_next       = ST_SZ_CNT;
            end
            else
            begin
                sb_next    = fin_size;
                state_next = ST_COMMIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rsp_valid_reg <= 1'b0;
            time_now_reg  <= '0;
            nv_reg        <= NV_RESET;
            clr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            time_now_reg  <= time_now_next;
            nv_reg        <= nv_next;
            clr_reg       <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        vb_reg         <= vb_next;
        t_reg          <= t_next;
        cur_reg        <= cur_next;
        ra_reg         <= ra_next;
        rb_reg         <= rb_next;
        scan_root_reg  <= scan_root_next;
        scan_b_reg     <= scan_b_next;
        cnt_reg        <= cnt_next;
        cnt_a_reg      <= cnt_a_next;
        idx_reg        <= idx_next;
        acc_reg        <= acc_next;
        sa_reg         <= sa_next;
        sb_reg         <= sb_next;
        res_flag_reg   <= res_flag_next;
        res_size_reg   <= res_size_next;
        res_status_reg <= res_status_next;
        out_flag_reg   <= out_flag_next;
        out_size_reg   <= out_size_next;
        out_time_reg   <= out_time_next;
        out_status_reg <= out_status_next;
    end

    `PPUF_ASSERT_IMP(a_link_wr_state, clk, rst_n, link_wr.en, (state_reg == ST_COMMIT || state_reg == ST_CLEAR), "link write outside commit or clear")
    `PPUF_ASSERT_IMP(a_entry_zero_kept, clk, rst_n, hist_wr.ent_en, (hist_wr.ent_addr[HIDX_W-1:0] != '0), "history entry zero overwritten")
    `PPUF_ASSERT_IMP(a_time_step, clk, rst_n, !$stable(time_now_reg), (time_now_reg == $past(time_now_reg) + TIME_W'(1)), "time moved by other than one")
    `PPUF_ASSERT_IMP(a_size_only_ok, clk, rst_n, (rsp_valid_reg && out_size_reg != '0), (out_status_reg == STAT_OK), "size reported with error status")
    `PPUF_ASSERT_NXT(a_accept_busy, clk, rst_n, (req.valid && req.ready), (state_reg != ST_IDLE), "request accepted without leaving idle")

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the partially persistent union-find unit.
`timescale 1ns / 1ps
module testbench;
    import ppuf_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned HOLD_CYCLES = 600;
    localparam int unsigned TAIL_CYCLES = 80;
    localparam int unsigned NUM_PHASES = 8;
    localparam int unsigned RANDOM_LIMIT_PHASE = 6;
    localparam int unsigned PRESSURE_PHASE = 3;
    localparam int unsigned PAUSE_PHASE = 4;
    localparam int unsigned PHASE_ITEMS [NUM_PHASES] = '{300, 60, 40, 300, 400, 200, 300, 400};
    localparam logic [NV_W-1:0] PHASE_LIMIT [NUM_PHASES] =
        '{11'd64, 11'd1, 11'd0, 11'd2047, 11'd1024, 11'd16, 11'd512, 11'd1024};

    typedef enum logic [1:0] {SINK_ALWAYS, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [VTX_W-1:0]  vertex_a;
        logic [VTX_W-1:0]  vertex_b;
        logic [TIME_W-1:0] query_time;
    } uf_request_t;

    typedef struct packed {
        logic              answer_flag;
        logic [SIZE_W-1:0] component_size;
        logic [TIME_W-1:0] current_time;
        logic [STAT_W-1:0] status;
    } uf_answer_t;

    typedef struct packed {
        logic            is_cfg;
        logic [NV_W-1:0] limit;
        uf_request_t     rq;
        logic            typed;
        uf_answer_t      ans;
    } stim_row_t;

    logic clk;
    logic rst_n;

    ppuf_cfg_if cfg_ch();
    ppuf_req_if req_ch();
    ppuf_rsp_if rsp_ch();

    partially_persistent_union_find_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the forest and its size histories
    logic [VTX_W-1:0]  shadow_parent    [VERTICES];
    logic [TIME_W-1:0] shadow_stamp     [VERTICES];
    logic [TIME_W-1:0] shadow_hist_time [VERTICES][HIST_DEPTH];
    logic [SIZE_W-1:0] shadow_hist_size [VERTICES][HIST_DEPTH];
    logic [HCNT_W-1:0] shadow_hist_cnt  [VERTICES];
    logic [TIME_W-1:0] shadow_now;
    logic [NV_W-1:0]   shadow_nv;

    uf_answer_t  pending_answers [$];
    stim_row_t   stim_rows [$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    sink_mode_t  sink_mode = SINK_ALWAYS;
    int unsigned hold_reqs = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned sink_tick = 0;
    logic [15:0] stall_pattern = 16'hffff;

    function automatic logic vertex_ok(logic [VTX_W-1:0] v);
        return NV_W'(v) < shadow_nv;
    endfunction

    // Follow links stamped no later than t.
    function automatic logic [VTX_W-1:0] root_at(logic [VTX_W-1:0] v, logic [TIME_W-1:0] t);
        logic [VTX_W-1:0] node;
        int steps;
        node = v;
        steps = 0;
        while (steps < VERTICES && shadow_stamp[node] <= t)
        begin
            node = shadow_parent[node];
            steps++;
        end
        return node;
    endfunction

    function automatic logic [SIZE_W-1:0] size_at(logic [VTX_W-1:0] root, logic [TIME_W-1:0] t);
        logic [SIZE_W-1:0] sz;
        logic stop;
        int i;
        sz = SIZE_W'(1);
        stop = 1'b0;
        for (i = 0; i < HIST_DEPTH; i++)
        begin
            if (!stop && i < int'(shadow_hist_cnt[root]))
            begin
                if (shadow_hist_time[root][i] <= t)
                    sz = shadow_hist_size[root][i];
                else
                    stop = 1'b1;
            end
        end
        return sz;
    endfunction

    function automatic uf_answer_t apply_request(uf_request_t rq);
        uf_answer_t ans;
        logic [VTX_W-1:0] ru, rv, tmp_r;
        logic [SIZE_W-1:0] su, sv, tmp_s;
        logic [TIME_W-1:0] prev;
        logic [HCNT_W-1:0] k;
        ans = '0;
        case (rq.kind)
            KIND_MERGE:
            begin
                if (!vertex_ok(rq.vertex_a) || !vertex_ok(rq.vertex_b))
                    ans.status = STAT_BAD_VTX;
                else if (shadow_now >= TIME_LAST)
                    ans.status = STAT_EXHAUSTED;
                else
                begin
                    prev = shadow_now;
                    ru = root_at(rq.vertex_a, prev);
                    rv = root_at(rq.vertex_b, prev);
                    shadow_now = prev + 1'b1;
                    if (ru != rv)
                    begin
                        su = size_at(ru, prev);
                        sv = size_at(rv, prev);
                        // on a tie the root of vertex_a survives
                        if (su < sv)
                        begin
                            tmp_r = ru;
                            ru = rv;
                            rv = tmp_r;
                            tmp_s = su;
                            su = sv;
                            sv = tmp_s;
                        end
                        if (shadow_hist_cnt[ru] >= HIST_DEPTH)
                            ans.status = STAT_HIST_FULL;
                        else
                        begin
                            k = shadow_hist_cnt[ru];
                            shadow_parent[rv] = ru;
                            shadow_stamp[rv] = shadow_now;
                            shadow_hist_time[ru][k[HIDX_W-1:0]] = shadow_now;
                            shadow_hist_size[ru][k[HIDX_W-1:0]] = su + sv;
                            shadow_hist_cnt[ru] = k + 1'b1;
                            ans.answer_flag = 1'b1;
                        end
                    end
                end
            end
            KIND_SAME:
            begin
                if (!vertex_ok(rq.vertex_a) || !vertex_ok(rq.vertex_b))
                    ans.status = STAT_BAD_VTX;
                else if (rq.query_time > shadow_now)
                    ans.status = STAT_LATE;
                else
                    ans.answer_flag = root_at(rq.vertex_a, rq.query_time) ==
                                      root_at(rq.vertex_b, rq.query_time);
            end
            KIND_SIZE:
            begin
                if (!vertex_ok(rq.vertex_a))
                    ans.status = STAT_BAD_VTX;
                else if (rq.query_time > shadow_now)
                    ans.status = STAT_LATE;
                else
                    ans.component_size = size_at(root_at(rq.vertex_a, rq.query_time),
                                                 rq.query_time);
            end
            default:
                ;
        endcase
        ans.current_time = shadow_now;
        return ans;
    endfunction

    // Often drawn from a small window of nodes so trees get deep and histories fill up.
    function automatic logic [VTX_W-1:0] random_vertex();
        int unsigned span;
        span = (shadow_nv > VERTICES) ? VERTICES : int'(shadow_nv);
        if (span == 0 || $urandom_range(0, 99) < 25)
            return VTX_W'($urandom);
        if ($urandom_range(0, 1) == 0)
            return VTX_W'($urandom_range(0, ((span > 48) ? 48 : span) - 1));
        return VTX_W'($urandom_range(0, span - 1));
    endfunction

    function automatic uf_request_t random_request();
        uf_request_t rq;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            rq.kind = KIND_MERGE;
        else if (pick < 75)
            rq.kind = KIND_SAME;
        else if (pick < 95)
            rq.kind = KIND_SIZE;
        else
            rq.kind = KIND_UNUSED;
        rq.vertex_a = random_vertex();
        rq.vertex_b = random_vertex();
        pick = $urandom_range(0, 99);
        if (pick < 80)
            rq.query_time = TIME_W'($urandom_range(0, int'(shadow_now)));
        else if (pick < 88)
            rq.query_time = shadow_now + 1'b1;
        else
            rq.query_time = TIME_W'($urandom);
        return rq;
    endfunction

    task automatic offer_request(input uf_request_t rq, input logic typed,
                                 input uf_answer_t typed_ans);
        uf_answer_t predicted;
        req_ch.valid <= 1'b1;
        req_ch.kind <= rq.kind;
        req_ch.vertex_a <= rq.vertex_a;
        req_ch.vertex_b <= rq.vertex_b;
        req_ch.query_time <= rq.query_time;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = apply_request(rq);
        pending_answers = {pending_answers, (typed ? typed_ans : predicted)};
    endtask

    task automatic rest_source(input int unsigned cycles);
        if (cycles != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic drain_answers();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    task automatic program_vertex_limit(input logic [NV_W-1:0] value);
        drain_answers();
        cfg_ch.valid <= 1'b1;
        cfg_ch.num_vertices <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        shadow_nv = value;
    endtask

    task automatic add_check(input logic [KIND_W-1:0] kind, input int unsigned a,
                             input int unsigned b, input int unsigned t,
                             input logic flag, input int unsigned sz,
                             input int unsigned now, input logic [STAT_W-1:0] status);
        stim_row_t row;
        row.is_cfg = 1'b0;
        row.limit = '0;
        row.rq = '{kind, VTX_W'(a), VTX_W'(b), TIME_W'(t)};
        row.typed = 1'b1;
        row.ans = '{flag, SIZE_W'(sz), TIME_W'(now), status};
        stim_rows = {stim_rows, row};
    endtask

    task automatic add_plain(input logic [KIND_W-1:0] kind, input int unsigned a,
                             input int unsigned b, input int unsigned t);
        stim_row_t row;
        row = '0;
        row.rq = '{kind, VTX_W'(a), VTX_W'(b), TIME_W'(t)};
        stim_rows = {stim_rows, row};
    endtask

    task automatic add_limit(input int unsigned value);
        stim_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.limit = NV_W'(value);
        stim_rows = {stim_rows, row};
    endtask

    task automatic run_rows();
        foreach (stim_rows[i])
        begin
            if (stim_rows[i].is_cfg)
                program_vertex_limit(stim_rows[i].limit);
            else
            begin
                offer_request(stim_rows[i].rq, stim_rows[i].typed, stim_rows[i].ans);
                rest_source($urandom_range(0, 2));
            end
        end
        stim_rows.delete();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: always ready, random or patterned stalls, plus long hold-offs on request.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            sink_tick++;
            if (sink_tick % 64 == 0)
                stall_pattern = 16'($urandom);
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (hold_served != hold_reqs)
            begin
                hold_served = hold_reqs;
                hold_left = HOLD_CYCLES - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                case (sink_mode)
                    SINK_ALWAYS:  rsp_ch.ready <= 1'b1;
                    SINK_RANDOM:  rsp_ch.ready <= ($urandom_range(0, 2) != 0);
                    default:      rsp_ch.ready <= stall_pattern[sink_tick % 16];
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : check_answers
        uf_answer_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("response word with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (rsp_ch.answer_flag !== want.answer_flag)
                begin
                    $error("answer_flag: expected %0d, got %0d",
                           want.answer_flag, rsp_ch.answer_flag);
                    mismatches++;
                end
                if (rsp_ch.component_size !== want.component_size)
                begin
                    $error("component_size: expected %0d, got %0d",
                           want.component_size, rsp_ch.component_size);
                    mismatches++;
                end
                if (rsp_ch.current_time !== want.current_time)
                begin
                    $error("current_time: expected %0d, got %0d",
                           want.current_time, rsp_ch.current_time);
                    mismatches++;
                end
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        logic [NV_W-1:0] limit_value;
        logic gaps_on;
        int unsigned p, n, k, burst_left;

        rst_n = 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.kind <= KIND_MERGE;
        req_ch.vertex_a <= '0;
        req_ch.vertex_b <= '0;
        req_ch.query_time <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.num_vertices <= '0;

        for (k = 0; k < VERTICES; k++)
        begin
            shadow_parent[k] = '0;
            shadow_stamp[k] = TIME_NEVER;
            shadow_hist_cnt[k] = HCNT_W'(1);
            for (n = 0; n < HIST_DEPTH; n++)
            begin
                shadow_hist_time[k][n] = '0;
                shadow_hist_size[k][n] = (n == 0) ? SIZE_W'(1) : '0;
            end
        end
        shadow_now = '0;
        shadow_nv = NV_RESET;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset state, extremes, every kind, tie, full history, bad nodes
        add_check(KIND_SIZE, 0, 0, 0, 1'b0, 1, 0, STAT_OK);
        add_check(KIND_SAME, 0, 1023, 0, 1'b0, 0, 0, STAT_OK);
        add_check(KIND_SIZE, 1023, 0, 1, 1'b0, 0, 0, STAT_LATE);
        add_check(KIND_UNUSED, 1023, 1023, 16'hffff, 1'b0, 0, 0, STAT_OK);
        add_check(KIND_MERGE, 5, 5, 0, 1'b0, 0, 1, STAT_OK);
        add_check(KIND_MERGE, 0, 1, 0, 1'b1, 0, 2, STAT_OK);
        for (k = 2; k <= 15; k++)
            add_plain(KIND_MERGE, 0, k, 16'hffff);
        // root 0 now holds a full history
        add_check(KIND_MERGE, 16, 0, 0, 1'b0, 0, 17, STAT_HIST_FULL);
        add_plain(KIND_SIZE, 15, 0, 3);
        add_plain(KIND_SAME, 1, 15, 16);
        add_limit(1000);
        add_check(KIND_MERGE, 1023, 0, 0, 1'b0, 0, 17, STAT_BAD_VTX);
        add_check(KIND_SAME, 0, 1000, 0, 1'b0, 0, 17, STAT_BAD_VTX);
        add_check(KIND_SIZE, 1000, 0, 16'hffff, 1'b0, 0, 17, STAT_BAD_VTX);
        run_rows();

        for (p = 0; p < NUM_PHASES; p++)
        begin
            limit_value = (p == RANDOM_LIMIT_PHASE) ? NV_W'($urandom_range(1, VERTICES))
                                                    : PHASE_LIMIT[p];
            program_vertex_limit(limit_value);
            sink_mode = (p == PRESSURE_PHASE) ? SINK_ALWAYS : sink_mode_t'($urandom_range(0, 2));
            gaps_on = (p != PRESSURE_PHASE) && ($urandom_range(0, 3) != 0);
            burst_left = $urandom_range(1, 16);
            for (n = 0; n < PHASE_ITEMS[p]; n++)
            begin
                if (p == PRESSURE_PHASE && n == 100)
                    hold_reqs++;
                if (p == PAUSE_PHASE && n == 200)
                    drain_answers();
                offer_request(random_request(), 1'b0, '0);
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    if (gaps_on)
                        rest_source($urandom_range(1, 12));
                end
            end
        end

        // Closing rows: widest query time, unused kind, single-node limit
        program_vertex_limit(NV_W'(VERTICES));
        sink_mode = SINK_ALWAYS;
        add_plain(KIND_MERGE, 2, 3, 0);
        add_plain(KIND_SAME, 4, 4, TIME_NEVER);
        add_plain(KIND_SIZE, 0, 0, 0);
        add_plain(KIND_SAME, 0, 1, 1);
        add_plain(KIND_UNUSED, 0, 0, 0);
        add_limit(1);
        add_plain(KIND_MERGE, 1, 0, 0);
        add_plain(KIND_MERGE, 0, 0, 0);
        run_rows();

        drain_answers();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_answers.size() != 0)
        begin
            $error("%0d responses never arrived", pending_answers.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/ppuf_pkg.sv
src/ppuf_ifs.sv
src/ppuf_link_store.sv
src/ppuf_hist_store.sv
src/ppuf_ctrl.sv
src/partially_persistent_union_find_unit.sv
verif/testbench.sv
